FILE: hdl/gaussian_smooth_and_normalize_top_assert.svh
// Assertion macros for the Gaussian smoothing block.
`ifndef GAUSSIAN_SMOOTH_AND_NORMALIZE_TOP_ASSERT_SVH
`define GAUSSIAN_SMOOTH_AND_NORMALIZE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define GSN_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gsn assertion failed");
`define GSN_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("gsn assertion failed");
`else
`define GSN_ASSERT(lbl, clk, rst_n, prop)
`define GSN_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: hdl/gsn_pkg.sv
// Shared constants, types and the controller state encoding of the smoothing block.
package gsn_pkg;

  localparam int HalfWidthDef = 6;
  localparam int CountBitsDef = 24;
  localparam int NumCoef      = 7;
  localparam int CoefW        = 16;
  localparam int BinW         = 24;
  localparam int SmoothW      = 40;
  localparam int RatioW       = 24;
  localparam int DigitW       = 4;
  localparam int NumDigits    = CoefW / DigitW;
  localparam int DigitIdxW    = $clog2(NumDigits);
  localparam int CfgIdxW      = 3;
  localparam int AccExtW      = 48;
  localparam int RatioShift   = 8;
  localparam int QuoCntW      = $clog2(RatioW);

  localparam logic [SmoothW-1:0] SmoothMax = '1;
  localparam logic [RatioW-1:0]  RatioMax  = '1;

  localparam logic [CfgIdxW-1:0] RegCoefCenter = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCoefOff6   = 3'd6;

  typedef logic [NumCoef-1:0][CoefW-1:0] coef_arr_t;

  localparam coef_arr_t CoefReset = {16'd145, 16'd575, 16'd1771, 16'd4249,
                                     16'd7937, 16'd11549, 16'd13086};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_MAC_GO,
    ST_MAC_WAIT,
    ST_DIV_WAIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

FILE: hdl/gsn_mac.sv
// Digit-serial multiply-accumulate over the symmetric kernel tap pairs.
module gsn_mac #(
  parameter int CntW  = 24,
  parameter int HalfW = 6,
  parameter int AccW  = 44
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [HalfW:0][CntW:0]       pair_i,
  input  gsn_pkg::coef_arr_t           coef_i,
  output logic [gsn_pkg::SmoothW-1:0]  smooth_o,
  output gsn_pkg::unit_stat_t          stat_o
);
  import gsn_pkg::*;

  localparam int GrpW  = $clog2(HalfW + 1);
  localparam int ProdW = CntW + 1 + DigitW;

  logic [GrpW-1:0]          grp_q;
  logic [DigitIdxW-1:0]     dig_q;
  logic                     busy_q;
  logic                     done_q;
  logic [AccW-1:0]          acc_q;
  logic [AccW-1:0]          acc_d;
  logic [AccW-1:0]          acc_base;
  logic [HalfW:0][CoefW-1:0] coef_use;
  logic [CntW:0]            pair_sel;
  logic [CoefW-1:0]         coef_sel;
  logic [DigitW-1:0]        digit;
  logic [ProdW-1:0]         prod;
  logic [AccExtW-1:0]       acc_ext;
  logic                     last_step;

  for (genvar g = 0; g <= HalfW; g++) begin : g_coef
    assign coef_use[g] = coef_i[g];
  end

  always_comb begin
    pair_sel  = pair_i[grp_q];
    coef_sel  = coef_use[grp_q];
    digit     = coef_sel[DigitW*dig_q +: DigitW];
    prod      = ProdW'(pair_sel) * ProdW'(digit);
    // Each new coefficient digit starts by scaling up what the previous digits gave.
    acc_base  = (grp_q == '0) ? (acc_q << DigitW) : acc_q;
    acc_d     = acc_base + AccW'(prod);
    last_step = busy_q && (grp_q == GrpW'(HalfW)) && (dig_q == '0);
    acc_ext   = AccExtW'(acc_q);
    smooth_o  = (|acc_ext[AccExtW-1:SmoothW]) ? SmoothMax : acc_ext[SmoothW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      grp_q  <= '0;
      dig_q  <= '0;
    end else begin
      done_q <= last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        grp_q  <= '0;
        dig_q  <= DigitIdxW'(NumDigits - 1);
      end else if (busy_q) begin
        if (grp_q == GrpW'(HalfW)) begin
          grp_q <= '0;
          dig_q <= dig_q - 1'b1;
        end else begin
          grp_q <= grp_q + 1'b1;
        end
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

FILE: hdl/gsn_div.sv
// Radix-2 restoring divider, saturated count/smoothed ratio as Q0.32 in 24 bits.
module gsn_div #(
  parameter int CntW = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [CntW-1:0]              count_i,
  input  logic [gsn_pkg::SmoothW-1:0]  smooth_i,
  output logic [gsn_pkg::RatioW-1:0]   ratio_o,
  output gsn_pkg::unit_stat_t          stat_o
);
  import gsn_pkg::*;

  logic [SmoothW:0]    num_hi;
  logic                is_zero;
  logic                is_sat;
  logic [SmoothW-1:0]  rem_q;
  logic [SmoothW-1:0]  den_q;
  logic [RatioW-1:0]   quo_q;
  logic [QuoCntW-1:0]  cnt_q;
  logic                busy_q;
  logic                done_q;
  logic [SmoothW:0]    trial;
  logic [SmoothW:0]    diff;
  logic                fits;

  always_comb begin
    num_hi  = (SmoothW + 1)'(count_i) << RatioShift;
    is_zero = (smooth_i == '0);
    // The quotient overflows 24 bits exactly when count * 2^8 reaches the divisor.
    is_sat  = (num_hi >= {1'b0, smooth_i});
    trial   = {rem_q, 1'b0};
    diff    = trial - {1'b0, den_q};
    fits    = (trial >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (is_zero || is_sat) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= QuoCntW'(RatioW - 1);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_hi[SmoothW-1:0];
      den_q <= smooth_i;
      if (is_zero) begin
        quo_q <= '0;
      end else if (is_sat) begin
        quo_q <= RatioMax;
      end else begin
        quo_q <= '0;
      end
    end else if (busy_q) begin
      rem_q <= fits ? diff[SmoothW-1:0] : trial[SmoothW-1:0];
      quo_q <= {quo_q[RatioW-2:0], fits};
    end
  end

  assign ratio_o     = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

FILE: hdl/gaussian_smooth_and_normalize_top.sv
// Top level: bin window, coefficient registers, sequencing and output register.
// A releasing bin's word passes the MAC digit loop, then the divider (cut short for a zero
// or saturated ratio), then the output register; a last bin flushes up to HALF_WIDTH+1
// results in turn. The next bin is taken only after the last owed word is loaded into the
// output register, and that load waits while a held word is not yet taken.
// Reset: asynchronous, active low; clears the window, loads default weights, ready at once.
`include "gaussian_smooth_and_normalize_top_assert.svh"

module gaussian_smooth_and_normalize_top #(
  parameter int HALF_WIDTH = gsn_pkg::HalfWidthDef,
  parameter int COUNT_BITS = gsn_pkg::CountBitsDef
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  // Input stream, one histogram bin per word.
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  logic [gsn_pkg::BinW-1:0]                   s_axis_tdata,  // [23:0] bin_count
  input  logic                                       s_axis_tlast,  // last_bin
  // Output stream, one smoothed bin per word.
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // [39:0] smoothed_value, [63:40] ratio_value
  output logic [gsn_pkg::SmoothW+gsn_pkg::RatioW-1:0] m_axis_tdata,
  output logic                                       m_axis_tlast,  // last_out
  // Coefficient write port.
  input  logic                                       cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  logic [gsn_pkg::CfgIdxW-1:0]                cfg_index_i,
  input  logic [gsn_pkg::CoefW-1:0]                  cfg_data_i
);
  import gsn_pkg::*;

  // Bins are masked to COUNT_BITS but never exceed the 24-bit field.
  localparam int CntW   = (COUNT_BITS < BinW) ? COUNT_BITS : BinW;
  localparam int WinLen = 2 * HALF_WIDTH + 1;
  localparam int AccW   = CntW + CoefW + $clog2(WinLen);
  localparam int FillW  = $clog2(HALF_WIDTH + 2);

  state_e                       state_q, state_d;
  coef_arr_t                    coef_q;
  logic [WinLen-1:0][CntW-1:0]  win_q;
  logic [FillW-1:0]             fill_q, fill_d;
  logic [FillW-1:0]             pre_q, pre_d;
  logic [FillW-1:0]             emit_q, emit_d;
  logic                         flush_q, flush_d;
  logic [FillW-1:0]             received;

  logic                         win_shift;
  logic                         win_clear;
  logic [CntW-1:0]              win_in;
  logic                         mac_start;
  logic                         div_start;
  logic                         out_load;
  logic                         last_word;

  logic [HALF_WIDTH:0][CntW:0]  pair;
  logic [SmoothW-1:0]           smooth;
  logic [RatioW-1:0]            ratio;
  unit_stat_t                   mac_stat;
  unit_stat_t                   div_stat;

  logic                         m_tvalid_q;
  logic [SmoothW-1:0]           m_smooth_q;
  logic [RatioW-1:0]            m_ratio_q;
  logic                         m_last_q;

  // Coefficients may be written at any time; indexes past the last one are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= CoefReset;
    end else if (cfg_valid_i && (cfg_index_i <= RegCoefOff6)) begin
      coef_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // The result is always computed for the bin in the middle of the window. On the
  // last bin, zeros are shifted in so that each pending bin passes the middle in turn,
  // which is the same as treating the bins after the end as empty.
  for (genvar g = 0; g <= HALF_WIDTH; g++) begin : g_pair
    if (g == 0) begin : g_mid
      assign pair[g] = {1'b0, win_q[HALF_WIDTH]};
    end else begin : g_side
      assign pair[g] = (CntW + 1)'(win_q[HALF_WIDTH-g]) + (CntW + 1)'(win_q[HALF_WIDTH+g]);
    end
  end

  always_comb begin
    state_d       = state_q;
    fill_d        = fill_q;
    pre_d         = pre_q;
    emit_d        = emit_q;
    flush_d       = flush_q;
    win_shift     = 1'b0;
    win_clear     = 1'b0;
    win_in        = '0;
    mac_start     = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    s_axis_tready = 1'b0;
    received      = fill_q + 1'b1;
    last_word     = flush_q && (emit_q == FillW'(1));

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          win_shift = 1'b1;
          win_in    = s_axis_tdata[CntW-1:0];
          if (fill_q < FillW'(HALF_WIDTH)) begin
            fill_d = fill_q + 1'b1;
          end
          if (s_axis_tlast) begin
            flush_d = 1'b1;
            if (received > FillW'(HALF_WIDTH)) begin
              emit_d  = FillW'(HALF_WIDTH + 1);
              state_d = ST_MAC_GO;
            end else begin
              // Short histogram: move its oldest bin to the middle first.
              emit_d  = received;
              pre_d   = FillW'(HALF_WIDTH + 1) - received;
              state_d = ST_SHIFT;
            end
          end else if (received > FillW'(HALF_WIDTH)) begin
            flush_d = 1'b0;
            emit_d  = FillW'(1);
            state_d = ST_MAC_GO;
          end
        end
      end
      ST_SHIFT: begin
        win_shift = 1'b1;
        pre_d     = pre_q - 1'b1;
        if (pre_q == FillW'(1)) begin
          state_d = ST_MAC_GO;
        end
      end
      ST_MAC_GO: begin
        mac_start = 1'b1;
        state_d   = ST_MAC_WAIT;
      end
      ST_MAC_WAIT: begin
        if (mac_stat.done) begin
          div_start = 1'b1;
          state_d   = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_tvalid_q || m_axis_tready) begin
          out_load = 1'b1;
          emit_d   = emit_q - 1'b1;
          if (emit_q == FillW'(1)) begin
            if (flush_q) begin
              win_clear = 1'b1;
              fill_d    = '0;
            end
            state_d = ST_IDLE;
          end else begin
            win_shift = 1'b1;
            state_d   = ST_MAC_GO;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      pre_q   <= '0;
      emit_q  <= '0;
      flush_q <= 1'b0;
      win_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      pre_q   <= pre_d;
      emit_q  <= emit_d;
      flush_q <= flush_d;
      if (win_clear) begin
        win_q <= '0;
      end else if (win_shift) begin
        win_q <= {win_q[WinLen-2:0], win_in};
      end
    end
  end

  gsn_mac #(
    .CntW  (CntW),
    .HalfW (HALF_WIDTH),
    .AccW  (AccW)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mac_start),
    .pair_i   (pair),
    .coef_i   (coef_q),
    .smooth_o (smooth),
    .stat_o   (mac_stat)
  );

  gsn_div #(
    .CntW (CntW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .count_i  (win_q[HALF_WIDTH]),
    .smooth_i (smooth),
    .ratio_o  (ratio),
    .stat_o   (div_stat)
  );

  // Output register: holds a finished word while the next bin is taken in.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (out_load) begin
      m_tvalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_smooth_q <= smooth;
      m_ratio_q  <= ratio;
      m_last_q   <= last_word;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = {m_ratio_q, m_smooth_q};
  assign m_axis_tlast  = m_last_q;

  `GSN_ASSERT(a_flush_clears_fill, clk_i, rst_ni, (out_load && last_word) |=> (fill_q == '0))
  `GSN_ASSERT(a_zero_ratio, clk_i, rst_ni, (m_tvalid_q && (m_smooth_q == '0)) |-> (m_ratio_q == '0))
  `GSN_ASSERT(a_units_exclusive, clk_i, rst_ni, !(mac_stat.busy && div_stat.busy))
  `GSN_ASSERT_ALWAYS(a_fill_bound, clk_i, !rst_ni || (fill_q <= FillW'(HALF_WIDTH)))

endmodule

FILE: tb/gaussian_smooth_and_normalize_top_tb.sv
// Self-checking testbench for the Gaussian histogram smoother, with its own bin-window model.
`timescale 1ns / 1ps

module gaussian_smooth_and_normalize_top_tb;
  import gsn_pkg::*;

  localparam int Half         = HalfWidthDef;
  localparam int WinLen       = 2 * Half + 1;
  // Per-result time in the block: digit-serial MAC plus the divider.
  localparam int ResultCycles = 4 * (Half + 1) + 28;
  localparam int SettleCycles = 2 * ResultCycles;
  localparam int HoldCycles   = 3000;
  localparam int CycleLimit   = 1_000_000;
  localparam int ItemsPerSet  = 40;
  localparam int NumSettings  = 8;
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  typedef struct packed {
    logic [SmoothW-1:0] smoothed;
    logic [RatioW-1:0]  ratio;
    logic               last;
  } smooth_word_t;

  // Tracks the bin window and kernel, and keeps the words the block still owes.
  class bin_smoother_model;
    logic [CoefW-1:0] kernel[NumCoef];
    logic [BinW-1:0]  window[WinLen];
    int               filled;
    smooth_word_t     owed_words[$];
    int               errors;
    int               checked;
    int               saturated;
    int               zero_smoothed;

    function new();
      for (int i = 0; i < NumCoef; i++) kernel[i] = CoefReset[i];
      clear_window();
      errors        = 0;
      checked       = 0;
      saturated     = 0;
      zero_smoothed = 0;
    endfunction

    function void clear_window();
      for (int i = 0; i < WinLen; i++) window[i] = '0;
      filled = 0;
    endfunction

    function void load_coef(logic [CfgIdxW-1:0] idx, logic [CoefW-1:0] val);
      if (idx <= RegCoefOff6) kernel[idx] = val;
    endfunction

    function int pending();
      return owed_words.size();
    endfunction

    // Smoothed value of the bin of the given age, with neighbors beyond the window as zero.
    function smooth_word_t smooth_bin(int age, logic is_last);
      logic [63:0]  sum;
      logic [63:0]  w;
      logic [63:0]  c;
      logic [63:0]  num;
      logic [63:0]  quo;
      int           a;
      int           off;
      smooth_word_t res;
      sum = '0;
      for (int d = -Half; d <= Half; d++) begin
        a   = age - d;
        off = (d < 0) ? -d : d;
        if (a >= 0 && a < WinLen) begin
          w   = {40'd0, window[a]};
          c   = {48'd0, kernel[off]};
          sum = sum + w * c;
        end
      end
      if (sum > {24'd0, SmoothMax}) begin
        res.smoothed = SmoothMax;
        saturated++;
      end else begin
        res.smoothed = sum[SmoothW-1:0];
      end
      if (res.smoothed == '0) begin
        res.ratio = '0;
        zero_smoothed++;
      end else begin
        num = {8'd0, window[age], 32'd0};
        quo = num / {24'd0, res.smoothed};
        res.ratio = (quo > {40'd0, RatioMax}) ? RatioMax : quo[RatioW-1:0];
      end
      res.last = is_last;
      return res;
    endfunction

    // Called for every accepted bin; queues the words that this bin releases.
    function void note_bin(logic [BinW-1:0] count, logic is_last);
      int received;
      int age;
      for (int i = WinLen - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = count;
      received  = filled + 1;
      if (filled < Half) filled++;
      if (!is_last) begin
        if (received > Half) owed_words.push_back(smooth_bin(Half, 1'b0));
      end else begin
        age = (received > Half) ? Half : received - 1;
        for (; age >= 0; age--) owed_words.push_back(smooth_bin(age, age == 0));
        clear_window();
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= 30) $display("tb: mismatch: %s", what);
    endtask

    task check_word(logic [SmoothW-1:0] smoothed, logic [RatioW-1:0] ratio, logic last);
      smooth_word_t exp_w;
      if (owed_words.size() == 0) begin
        report($sformatf("unexpected word smoothed=%0h ratio=%0h last=%0b",
                         smoothed, ratio, last));
      end else begin
        exp_w = owed_words.pop_front();
        checked++;
        if (smoothed !== exp_w.smoothed)
          report($sformatf("word %0d smoothed %0h, expected %0h",
                           checked, smoothed, exp_w.smoothed));
        if (ratio !== exp_w.ratio)
          report($sformatf("word %0d ratio %0h, expected %0h", checked, ratio, exp_w.ratio));
        if (last !== exp_w.last)
          report($sformatf("word %0d last %0b, expected %0b", checked, last, exp_w.last));
      end
    endtask
  endclass

  logic                       clk_i;
  logic                       rst_ni        = 1'b0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [BinW-1:0]            s_axis_tdata  = '0;
  logic                       s_axis_tlast  = 1'b0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [SmoothW+RatioW-1:0]  m_axis_tdata;
  logic                       m_axis_tlast;
  logic                       cfg_valid_i   = 1'b0;
  logic                       cfg_ready_o;
  logic [CfgIdxW-1:0]         cfg_index_i   = '0;
  logic [CoefW-1:0]           cfg_data_i    = '0;

  bin_smoother_model smoother = new();

  int gap_pct       = 0;
  int stall_pct     = 0;
  bit hold_req      = 1'b0;
  int hold_left     = 0;
  int bins_sent     = 0;
  int histograms    = 0;
  int input_stalls  = 0;

  gaussian_smooth_and_normalize_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The receiver stalls at random, or holds off for a long stretch when asked, so
  // that the block backs up into its input.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Every word taken from the block is compared against the oldest owed word.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      smoother.check_word(m_axis_tdata[SmoothW-1:0], m_axis_tdata[SmoothW+RatioW-1:SmoothW],
                          m_axis_tlast);
    if (rst_ni && s_axis_tvalid && !s_axis_tready) input_stalls++;
  end

  // Hard stop for a hung block.
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  // Offers one bin and waits for it to be taken; the valid stays high afterward.
  task send_bin(input logic [BinW-1:0] count, input logic is_last);
    while ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= count;
    s_axis_tlast  <= is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    smoother.note_bin(count, is_last);
    bins_sent++;
    if (is_last) histograms++;
  endtask

  // Writes the whole kernel, and optionally pokes the unused register index.
  task load_kernel(input coef_arr_t k, input bit poke_unused);
    for (int r = RegCoefCenter; r <= RegCoefOff6 + poke_unused; r++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= r[CfgIdxW-1:0];
      cfg_data_i  <= (r == RegUnused) ? CoefW'($urandom) : k[r];
      do @(posedge clk_i); while (!cfg_ready_o);
      smoother.load_coef(cfg_index_i, cfg_data_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every owed word has come back, then lets the block settle.
  task wait_drained();
    while (smoother.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [BinW-1:0] pick_count(int style);
    case (style)
      0:       return BinW'($urandom);
      1:       return BinW'($urandom_range(0, 1023));
      2:       return ($urandom_range(0, 3) == 0) ? BinW'($urandom) : '0;
      default: return ($urandom_range(0, 1) == 1) ? '1 : '0;
    endcase
  endfunction

  // Whole histograms of random length and content, each with its own idle mode.
  task run_histograms(input int n_items);
    int done_items;
    int len;
    int sel;
    int style;
    done_items = 0;
    while (done_items < n_items) begin
      sel = $urandom_range(0, 9);
      if (sel < 3)      len = $urandom_range(1, Half + 1);
      else if (sel < 9) len = $urandom_range(Half + 2, 24);
      else              len = $urandom_range(25, 60);
      style = $urandom_range(0, 3);
      case ($urandom_range(0, 3))
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 46; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 46; end
        default: begin gap_pct = 8; stall_pct = 8; end
      endcase
      for (int b = 0; b < len; b++) send_bin(pick_count(style), b == len - 1);
      done_items += len;
    end
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    coef_arr_t k;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the default kernel: a lone full-scale bin, a lone empty
    // bin (zero smoothed value, so zero ratio), a short histogram, one of exactly
    // HALF_WIDTH+1 bins, and one that alternates between the count extremes.
    send_bin('1, 1'b1);
    send_bin('0, 1'b1);
    send_bin(24'd1, 1'b0);
    send_bin(24'h800000, 1'b0);
    send_bin(24'h7FFFFF, 1'b1);
    for (int b = 0; b <= Half; b++) send_bin(BinW'(b * 1000 + 1), b == Half);
    for (int b = 0; b < 9; b++) send_bin((b % 2) ? '1 : '0, b == 8);
    s_axis_tvalid <= 1'b0;
    wait_drained();

    for (int s = 0; s < NumSettings; s++) begin
      case (s)
        0: k = '1;             // weights sum far above one: saturation
        1: k = '0;             // every smoothed value is zero
        2: begin
          k = '0;
          k[RegCoefCenter] = 16'd1;   // tiny smoothed values: the ratio saturates
        end
        3: k = CoefReset;
        default: begin
          for (int r = 0; r < NumCoef; r++)
            k[r] = (s == 4) ? CoefW'($urandom) : CoefW'($urandom_range(0, 8191));
        end
      endcase
      load_kernel(k, s == NumSettings - 1);
      if (s == 0) begin
        for (int b = 0; b < 3; b++) send_bin('1, b == 2);
      end
      if (s == 3) begin
        // Hold the receiver off while a long histogram keeps arriving, so the block
        // fills up and pushes back on its input.
        gap_pct   = 0;
        stall_pct = 0;
        hold_req  = 1'b1;
        for (int b = 0; b < 40; b++) send_bin(BinW'($urandom), b == 39);
      end
      run_histograms(ItemsPerSet);
      wait_drained();
    end

    if (smoother.pending() != 0)
      smoother.report($sformatf("%0d expected words never arrived", smoother.pending()));
    $display("tb: %0d bins in %0d histograms over %0d kernel settings, %0d words checked",
             bins_sent, histograms, NumSettings + 1, smoother.checked);
    $display("tb: %0d saturated sums, %0d zero sums, %0d cycles of input back-pressure",
             smoother.saturated, smoother.zero_smoothed, input_stalls);
    if (smoother.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
